### rtl/gww_pkg.sv
// Package for the greedy word wrapper: item types, sequencer states and
// character constants. No dependencies.
`timescale 1ns / 1ps
package gww_pkg;

  localparam int CHAR_W = 8;

  localparam logic [CHAR_W-1:0] CHAR_NL  = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_SP  = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_CR  = 8'h0D;

  localparam logic [1:0] NL_SAT = 2'd2;

  localparam logic KIND_TEXT  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic [CHAR_W-1:0] LINE_WIDTH_RST = 8'd20;

  typedef struct packed {
    logic              kind;
    logic [CHAR_W-1:0] char_in;
  } gww_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_byte;
    logic              end_of_run;
    logic              too_big_seen;
    logic              word_truncated;
  } gww_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BLANK1,
    S_BLANK2,
    S_SEP,
    S_WORD,
    S_FINAL
  } gww_state_t;

endpackage

### rtl/gww_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module gww_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 60,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/greedy_word_wrap.sv
// Greedy word wrapper top level: word buffer in gww_ram, emit sequencer,
// output register. Depends on gww_pkg and gww_ram.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid/in_ready/in_data) carries one text byte or an
//   end-of-text item. Output channel (out_valid/out_ready/out_data) carries
//   the wrapped text, one byte per item, with end_of_run on the last byte an
//   input item caused, and the two sticky flags after that item.
//   cfg_we/cfg_wdata write line_width; write it only while the block is idle.
// Timing
//   A non-space byte is written to the word RAM as it is accepted; the block
//   stays idle, so the next item can be taken in the following cycle.
//   A space that ends a stored word, or an end of text, starts a run of
//   output bytes, one per cycle while the output register can take one:
//   2 for a blank line, 0 or 1 for the separator, one per word byte, 1 for
//   the final newline of end of text. in_ready stays low from the accepting
//   edge until the last byte of the run has entered the output register.
// Reset
//   rst_n low clears word length, line position, newline count, both flags
//   and sets line_width to 20. The word RAM is not cleared.
// Stall
//   Hold the output byte while out_ready is low and stall the sequencer;
//   the last byte of a run may wait there while the next item is taken.
module greedy_word_wrap #(
  parameter int MAX_WORD = 60
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  gww_pkg::gww_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output gww_pkg::gww_out_t out_data,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata
);

  localparam int AW    = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int LEN_W = $clog2(MAX_WORD + 1);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WORD);

  // Control and context registers
  gww_pkg::gww_state_t state_r, state_nxt;
  logic [LEN_W-1:0]         word_len_r, word_len_nxt;
  logic [LEN_W-1:0]         idx_r, idx_nxt;
  logic [7:0]               line_pos_r, line_pos_nxt;
  logic [1:0]               nl_cnt_r, nl_cnt_nxt;
  logic                     too_big_r, too_big_nxt;
  logic                     trunc_r, trunc_nxt;
  logic [7:0]               line_width_r, line_width_nxt;
  logic                     sep_r, sep_nxt;
  logic [7:0]               sep_byte_r, sep_byte_nxt;
  logic                     final_r, final_nxt;
  logic                     out_valid_r, out_valid_nxt;
  gww_pkg::gww_out_t        out_data_r, out_data_nxt;

  // Input decode
  logic       in_fire;
  logic       is_space;
  logic       ends_word;
  logic       start_emit;
  logic       has_word;
  logic       text_store;

  // Emission plan for the word ending now
  logic        blank_c;
  logic [7:0]  pos0_c;
  logic [9:0]  room_c;
  logic [9:0]  need_c;
  logic        wrap_c;
  logic        sep_c;
  logic [7:0]  sep_byte_c;

  // Sequencer step
  logic        slot_free;
  logic        step;
  logic        word_last;
  logic [7:0]  emit_byte;
  logic        emit_last;

  // RAM ports
  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic          ram_rd_en;
  logic [AW-1:0] ram_rd_addr;
  logic [7:0]    ram_rd_data;

  assign in_ready   = (state_r == gww_pkg::S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign is_space   = (in_data.char_in == gww_pkg::CHAR_SP) ||
                      (in_data.char_in == gww_pkg::CHAR_NUL) ||
                      ((in_data.char_in >= gww_pkg::CHAR_TAB) &&
                       (in_data.char_in <= gww_pkg::CHAR_CR));
  assign has_word   = (word_len_r != '0);
  assign ends_word  = in_fire && ((in_data.kind == gww_pkg::KIND_FLUSH) || is_space);
  assign start_emit = ends_word && ((in_data.kind == gww_pkg::KIND_FLUSH) || has_word);
  assign text_store = in_fire && (in_data.kind == gww_pkg::KIND_TEXT) && !is_space &&
                      (word_len_r < MAX_LEN);

  // A blank line resets the line, then decide wrap against the signed room.
  assign blank_c    = (nl_cnt_r == gww_pkg::NL_SAT);
  assign pos0_c     = blank_c ? 8'd0 : line_pos_r;
  assign room_c     = {2'b00, line_width_r} - {2'b00, pos0_c};
  assign need_c     = 10'(word_len_r) + 10'd1;
  assign wrap_c     = ($signed(room_c) < $signed(need_c));
  assign sep_c      = wrap_c || (pos0_c != 8'd0);
  assign sep_byte_c = wrap_c ? gww_pkg::CHAR_NL : gww_pkg::CHAR_SP;

  assign slot_free  = !out_valid_r || out_ready;
  assign step       = (state_r != gww_pkg::S_IDLE) && slot_free;
  assign word_last  = ((idx_r + LEN_W'(1)) == word_len_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gww_pkg::S_IDLE: begin
        if (start_emit) begin
          if (!has_word) begin
            state_nxt = gww_pkg::S_FINAL;
          end else if (blank_c) begin
            state_nxt = gww_pkg::S_BLANK1;
          end else if (sep_c) begin
            state_nxt = gww_pkg::S_SEP;
          end else begin
            state_nxt = gww_pkg::S_WORD;
          end
        end
      end
      gww_pkg::S_BLANK1: begin
        if (step) state_nxt = gww_pkg::S_BLANK2;
      end
      gww_pkg::S_BLANK2: begin
        if (step) state_nxt = sep_r ? gww_pkg::S_SEP : gww_pkg::S_WORD;
      end
      gww_pkg::S_SEP: begin
        if (step) state_nxt = gww_pkg::S_WORD;
      end
      gww_pkg::S_WORD: begin
        if (step && word_last) state_nxt = final_r ? gww_pkg::S_FINAL : gww_pkg::S_IDLE;
      end
      gww_pkg::S_FINAL: begin
        if (step) state_nxt = gww_pkg::S_IDLE;
      end
      default: state_nxt = gww_pkg::S_IDLE;
    endcase
  end

  // Byte produced by the current state
  always_comb begin
    emit_byte = gww_pkg::CHAR_NL;
    emit_last = 1'b0;
    unique case (state_r)
      gww_pkg::S_IDLE:   emit_byte = gww_pkg::CHAR_NL;
      gww_pkg::S_BLANK1: emit_byte = gww_pkg::CHAR_NL;
      gww_pkg::S_BLANK2: emit_byte = gww_pkg::CHAR_NL;
      gww_pkg::S_SEP:    emit_byte = sep_byte_r;
      gww_pkg::S_WORD: begin
        emit_byte = ram_rd_data;
        emit_last = word_last && !final_r;
      end
      gww_pkg::S_FINAL: begin
        emit_byte = gww_pkg::CHAR_NL;
        emit_last = 1'b1;
      end
      default: emit_byte = gww_pkg::CHAR_NL;
    endcase
  end

  // RAM access: store at the word end, prefetch byte 0 at the accepting
  // edge, then fetch the next byte each time one leaves.
  assign ram_wr_en   = text_store;
  assign ram_wr_addr = word_len_r[AW-1:0];
  assign ram_rd_en   = start_emit ||
                       ((state_r == gww_pkg::S_WORD) && step && !word_last);
  assign ram_rd_addr = start_emit ? '0 : idx_nxt[AW-1:0];

  // Datapath next values
  always_comb begin
    word_len_nxt   = word_len_r;
    idx_nxt        = idx_r;
    line_pos_nxt   = line_pos_r;
    nl_cnt_nxt     = nl_cnt_r;
    too_big_nxt    = too_big_r;
    trunc_nxt      = trunc_r;
    line_width_nxt = cfg_we ? cfg_wdata : line_width_r;
    sep_nxt        = sep_r;
    sep_byte_nxt   = sep_byte_r;
    final_nxt      = final_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (text_store) begin
      word_len_nxt = word_len_r + LEN_W'(1);
    end else if (in_fire && (in_data.kind == gww_pkg::KIND_TEXT) && !is_space) begin
      // Drop bytes past the buffer and mark the cut.
      trunc_nxt = 1'b1;
    end

    if (ends_word) begin
      final_nxt = (in_data.kind == gww_pkg::KIND_FLUSH);
      sep_nxt   = sep_c;
      sep_byte_nxt = sep_byte_c;
      idx_nxt   = '0;
      if (has_word) begin
        if (wrap_c) begin
          if (9'(word_len_r) > {1'b0, line_width_r}) too_big_nxt = 1'b1;
          line_pos_nxt = 8'(word_len_r);
        end else begin
          line_pos_nxt = pos0_c + {7'd0, (pos0_c != 8'd0)} + 8'(word_len_r);
        end
      end
      if (in_data.kind == gww_pkg::KIND_FLUSH) begin
        line_pos_nxt = 8'd0;
        nl_cnt_nxt   = 2'd0;
      end else begin
        if (has_word) nl_cnt_nxt = 2'd0;
        if (in_data.char_in == gww_pkg::CHAR_NL) begin
          if (has_word) begin
            nl_cnt_nxt = 2'd1;
          end else if (nl_cnt_r < gww_pkg::NL_SAT) begin
            nl_cnt_nxt = nl_cnt_r + 2'd1;
          end
        end
      end
    end

    if (step) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.out_byte        = emit_byte;
      out_data_nxt.end_of_run      = emit_last;
      out_data_nxt.too_big_seen    = too_big_r;
      out_data_nxt.word_truncated  = trunc_r;
      if (state_r == gww_pkg::S_WORD) begin
        idx_nxt = idx_r + LEN_W'(1);
        // Clear the buffer once its last byte is out.
        if (word_last) word_len_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gww_pkg::S_IDLE;
      word_len_r   <= '0;
      idx_r        <= '0;
      line_pos_r   <= 8'd0;
      nl_cnt_r     <= 2'd0;
      too_big_r    <= 1'b0;
      trunc_r      <= 1'b0;
      line_width_r <= gww_pkg::LINE_WIDTH_RST;
      sep_r        <= 1'b0;
      final_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      word_len_r   <= word_len_nxt;
      idx_r        <= idx_nxt;
      line_pos_r   <= line_pos_nxt;
      nl_cnt_r     <= nl_cnt_nxt;
      too_big_r    <= too_big_nxt;
      trunc_r      <= trunc_nxt;
      line_width_r <= line_width_nxt;
      sep_r        <= sep_nxt;
      final_r      <= final_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    sep_byte_r <= sep_byte_nxt;
    out_data_r <= out_data_nxt;
  end

  gww_ram #(
    .WIDTH  (8),
    .DEPTH  (MAX_WORD),
    .ADDR_W (AW)
  ) u_word_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (in_data.char_in),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Word buffer never fills past its depth.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    word_len_r <= MAX_LEN)
    else $error("word length beyond buffer depth");

  // While reading back a word the index stays inside it.
  a_idx_in_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == gww_pkg::S_WORD) |-> (idx_r < word_len_r))
    else $error("read index outside current word");

  // Sticky flags never clear outside reset.
  a_flags_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (trunc_r || too_big_r) |=> ((trunc_r || !$past(trunc_r)) &&
                                (too_big_r || !$past(too_big_r))))
    else $error("sticky flag cleared");

endmodule
